// File: src/sbfd_pkg.sv
`default_nettype none
package sbfd_pkg;

   localparam int FRAME_BYTES  = 25;
   localparam int NUM_CHANNELS = 16;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 5;
   localparam int CH_W    = 4;
   localparam int RAW_W   = 11;
   localparam int GAIN_W  = 16;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 16;
   localparam int PROD_W  = RAW_W + GAIN_W;
   // leftover bits stay below RAW_W, so one byte on top of them fits here
   localparam int ACC_W   = RAW_W - 1 + BYTE_W;
   localparam int NBITS_W = 5;

   localparam int FRAC_BITS    = 12;
   localparam int HALF_LSB     = 2048;
   localparam int FLAGS_POS    = 23;
   localparam int FAILSAFE_BIT = 3;
   localparam int LOST_BIT     = 2;
   localparam int SWEEP_LAST   = (RAW_W * NUM_CHANNELS - 1) / BYTE_W + 1;

   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h0F;
   localparam logic [BYTE_W-1:0] FTR_BYTE = 8'h00;

   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd2560;
   localparam logic [VALUE_W-1:0] OFFSET_RESET = 16'd880;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_GAP  = 1'b1;

   localparam logic CSR_SCALE_GAIN   = 1'b0;
   localparam logic CSR_SCALE_OFFSET = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel_index;
      logic [VALUE_W-1:0] channel_value;
      logic               failsafe_flag;
      logic               signal_lost_flag;
      logic [COUNT_W-1:0] lost_frame_count;
      logic               last_of_frame;
   } rsp_item_type;

   typedef struct packed {
      logic [RAW_W-1:0]   raw;
      logic [CH_W-1:0]    channel_index;
      logic               failsafe_flag;
      logic               signal_lost_flag;
      logic [COUNT_W-1:0] lost_frame_count;
      logic               last_of_frame;
   } chan_item_type;

   typedef struct packed {
      logic advance;
      logic busy;
   } scale_status_type;

endpackage
`default_nettype wire

// File: src/sbfd_scale.sv
`default_nettype none
module sbfd_scale (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_valid,
   input  sbfd_pkg::chan_item_type         in_item,
   input  wire [sbfd_pkg::GAIN_W-1:0]      scale_gain,
   input  wire signed [sbfd_pkg::VALUE_W-1:0] scale_offset,
   output sbfd_pkg::scale_status_type      status,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output sbfd_pkg::rsp_item_type          rsp_data
);

   localparam int RND_W = sbfd_pkg::PROD_W + 1;
   localparam int SH_W  = RND_W - sbfd_pkg::FRAC_BITS;
   localparam int SUM_W = sbfd_pkg::VALUE_W + 2;

   logic                          prod_vld_ff, prod_vld_in;
   logic [sbfd_pkg::PROD_W-1:0]   prod_ff, prod_in;
   sbfd_pkg::chan_item_type       prod_item_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   sbfd_pkg::rsp_item_type        rsp_data_ff, rsp_data_in;

   logic                          advance;
   logic [RND_W-1:0]              rnd;
   logic [SH_W-1:0]               shifted;
   logic signed [SUM_W-1:0]       sum;
   logic [sbfd_pkg::VALUE_W-1:0]  value;

   // the whole pipe moves only when the output slot is free or being taken
   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      prod_in     = sbfd_pkg::PROD_W'(in_item.raw) * sbfd_pkg::PROD_W'(scale_gain);
      prod_vld_in = advance ? in_valid : prod_vld_ff;

      rnd     = {1'b0, prod_ff} + RND_W'(sbfd_pkg::HALF_LSB);
      shifted = rnd[RND_W-1:sbfd_pkg::FRAC_BITS];
      sum     = $signed(SUM_W'(shifted))
              + $signed({{(SUM_W - sbfd_pkg::VALUE_W){scale_offset[sbfd_pkg::VALUE_W-1]}},
                         scale_offset});
      if (sum[SUM_W-1]) begin
         value = '0;
      end else if (sum[SUM_W-2:sbfd_pkg::VALUE_W] != '0) begin
         value = '1;
      end else begin
         value = sum[sbfd_pkg::VALUE_W-1:0];
      end

      rsp_valid_in = advance ? prod_vld_ff : rsp_valid_ff;
      rsp_data_in.channel_index    = prod_item_ff.channel_index;
      rsp_data_in.channel_value    = value;
      rsp_data_in.failsafe_flag    = prod_item_ff.failsafe_flag;
      rsp_data_in.signal_lost_flag = prod_item_ff.signal_lost_flag;
      rsp_data_in.lost_frame_count = prod_item_ff.lost_frame_count;
      rsp_data_in.last_of_frame    = prod_item_ff.last_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff      <= prod_in;
         prod_item_ff <= in_item;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign status.advance = advance;
   assign status.busy    = prod_vld_ff || rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

endmodule
`default_nettype wire

// File: src/sbus_frame_decoder_top.sv
`default_nettype none
// Serial-bus servo frame decoder.
// req channel: one transfer per received byte (req_type byte) or per idle
// gap between frames (req_type gap). Bytes are written into a 25-entry frame
// memory as they arrive, one per cycle while req_ready is high.
// On the 25th byte, header 0x0F and footer 0x00 are checked. A good frame
// starts a sweep that reads bytes 1..22 from the memory one per cycle,
// unpacks 16 channels of 11 bits and scales each with a multiply stage and
// a round/offset/saturate stage. The first rsp transfer follows the sweep
// flag, fetched byte, channel and two scale registers; results are paced by
// the single memory read port, one byte a cycle unless rsp_ready stalls.
// req_ready is low from the closing byte of a good frame until the last
// channel result has been taken. A bad frame gives no result and does not
// stall. An idle gap during a partial frame bumps the lost-frame count.
// csr channel: always ready; index 0 scale_gain, 1 scale_offset; write only
// while idle. While rsp_valid waits on rsp_ready, sweep and both stages hold.
// Reset clears the byte position, the lost-frame count and the pipeline
// valids and restores the register defaults; the frame memory is not cleared.
module sbus_frame_decoder_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  sbfd_pkg::req_item_type             req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output sbfd_pkg::rsp_item_type             rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire                                csr_index,
   input  wire [sbfd_pkg::VALUE_W-1:0]        csr_wdata
);

   logic [sbfd_pkg::BYTE_W-1:0] store_mem [sbfd_pkg::FRAME_BYTES];

   logic [sbfd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [sbfd_pkg::COUNT_W-1:0] lost_ff, lost_in;
   logic                         hdr_ok_ff, hdr_ok_in;
   logic                         failsafe_ff, failsafe_in;
   logic                         siglost_ff, siglost_in;
   logic [sbfd_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [sbfd_pkg::VALUE_W-1:0] offset_ff, offset_in;
   logic                         sweep_ff, sweep_in;
   logic [sbfd_pkg::POS_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [sbfd_pkg::BYTE_W-1:0]  rdata_ff;
   logic [sbfd_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [sbfd_pkg::NBITS_W-1:0] nbits_ff, nbits_in;
   logic [sbfd_pkg::CH_W-1:0]    ch_ff, ch_in;
   logic                         chan_vld_ff, chan_vld_in;
   sbfd_pkg::chan_item_type      chan_ff, chan_in;

   sbfd_pkg::scale_status_type   scale_status;
   logic                         req_fire, byte_fire, csr_fire, advance, start, emit;
   logic [sbfd_pkg::ACC_W-1:0]   merged;
   logic [sbfd_pkg::NBITS_W-1:0] merged_bits;

   assign advance   = scale_status.advance;
   assign req_ready = !(sweep_ff || rd_vld_ff || chan_vld_ff || scale_status.busy);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign byte_fire = req_fire && (req_data.req_type == sbfd_pkg::REQ_BYTE);
   assign csr_fire  = csr_valid && csr_ready;
   assign start     = byte_fire && (pos_ff == sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES - 1))
                    && hdr_ok_ff && (req_data.data_byte == sbfd_pkg::FTR_BYTE);

   always_comb begin
      pos_in      = pos_ff;
      lost_in     = lost_ff;
      hdr_ok_in   = hdr_ok_ff;
      failsafe_in = failsafe_ff;
      siglost_in  = siglost_ff;
      if (req_fire) begin
         if (req_data.req_type == sbfd_pkg::REQ_GAP) begin
            if (pos_ff != '0) begin
               if (lost_ff != '1) begin
                  lost_in = lost_ff + 1'b1;
               end
               pos_in = '0;
            end
         end else begin
            if (pos_ff == '0) begin
               hdr_ok_in = (req_data.data_byte == sbfd_pkg::HDR_BYTE);
            end
            if (pos_ff == sbfd_pkg::POS_W'(sbfd_pkg::FLAGS_POS)) begin
               failsafe_in = req_data.data_byte[sbfd_pkg::FAILSAFE_BIT];
               siglost_in  = req_data.data_byte[sbfd_pkg::LOST_BIT];
            end
            if (pos_ff == sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES - 1)) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end

      gain_in   = gain_ff;
      offset_in = offset_ff;
      if (csr_fire) begin
         case (csr_index)
            sbfd_pkg::CSR_SCALE_GAIN:   gain_in   = csr_wdata;
            sbfd_pkg::CSR_SCALE_OFFSET: offset_in = csr_wdata;
            default: ;
         endcase
      end

      // append the fetched byte above the leftover bits, cut off a full channel
      merged      = acc_ff;
      merged_bits = nbits_ff;
      if (rd_vld_ff) begin
         merged      = acc_ff | (sbfd_pkg::ACC_W'(rdata_ff) << nbits_ff);
         merged_bits = nbits_ff + sbfd_pkg::NBITS_W'(sbfd_pkg::BYTE_W);
      end
      emit = (merged_bits >= sbfd_pkg::NBITS_W'(sbfd_pkg::RAW_W));

      sweep_in    = sweep_ff;
      rd_addr_in  = rd_addr_ff;
      rd_vld_in   = rd_vld_ff;
      acc_in      = acc_ff;
      nbits_in    = nbits_ff;
      ch_in       = ch_ff;
      chan_vld_in = chan_vld_ff;
      chan_in     = chan_ff;
      if (advance) begin
         rd_vld_in   = sweep_ff;
         chan_vld_in = emit;
         if (sweep_ff) begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == sbfd_pkg::POS_W'(sbfd_pkg::SWEEP_LAST)) begin
               sweep_in = 1'b0;
            end
         end
         if (emit) begin
            acc_in   = merged >> sbfd_pkg::RAW_W;
            nbits_in = merged_bits - sbfd_pkg::NBITS_W'(sbfd_pkg::RAW_W);
            ch_in    = ch_ff + 1'b1;
         end else begin
            acc_in   = merged;
            nbits_in = merged_bits;
         end
         chan_in.raw              = merged[sbfd_pkg::RAW_W-1:0];
         chan_in.channel_index    = ch_ff;
         chan_in.failsafe_flag    = failsafe_ff;
         chan_in.signal_lost_flag = siglost_ff;
         chan_in.lost_frame_count = lost_ff;
         chan_in.last_of_frame    = (ch_ff == sbfd_pkg::CH_W'(sbfd_pkg::NUM_CHANNELS - 1));
      end
      if (start) begin
         sweep_in   = 1'b1;
         rd_addr_in = sbfd_pkg::POS_W'(1);
         acc_in     = '0;
         nbits_in   = '0;
         ch_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         lost_ff     <= '0;
         hdr_ok_ff   <= 1'b0;
         gain_ff     <= sbfd_pkg::GAIN_RESET;
         offset_ff   <= sbfd_pkg::OFFSET_RESET;
         sweep_ff    <= 1'b0;
         rd_addr_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         nbits_ff    <= '0;
         ch_ff       <= '0;
         chan_vld_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         lost_ff     <= lost_in;
         hdr_ok_ff   <= hdr_ok_in;
         gain_ff     <= gain_in;
         offset_ff   <= offset_in;
         sweep_ff    <= sweep_in;
         rd_addr_ff  <= rd_addr_in;
         rd_vld_ff   <= rd_vld_in;
         nbits_ff    <= nbits_in;
         ch_ff       <= ch_in;
         chan_vld_ff <= chan_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      failsafe_ff <= failsafe_in;
      siglost_ff  <= siglost_in;
      acc_ff      <= acc_in;
      chan_ff     <= chan_in;
   end

   always_ff @(posedge clock) begin
      if (byte_fire) begin
         store_mem[pos_ff] <= req_data.data_byte;
      end
   end

   // read enable follows the pipe, so a stall holds the fetched byte
   always_ff @(posedge clock) begin
      if (advance && sweep_ff) begin
         rdata_ff <= store_mem[rd_addr_ff];
      end
   end

   sbfd_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chan_vld_ff),
      .in_item      (chan_ff),
      .scale_gain   (gain_ff),
      .scale_offset (offset_ff),
      .status       (scale_status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES - 1))
      else $error("byte position beyond frame");

   a_nbits_below_raw: assert property (@(posedge clock) disable iff (reset)
      nbits_ff < sbfd_pkg::NBITS_W'(sbfd_pkg::RAW_W))
      else $error("unpack leftover holds a whole channel");

   a_sweep_addr: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> (rd_addr_ff >= sbfd_pkg::POS_W'(1))
                && (rd_addr_ff <= sbfd_pkg::POS_W'(sbfd_pkg::SWEEP_LAST)))
      else $error("sweep address outside channel bytes");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sweep_ff && !rsp_valid && (nbits_ff == '0))
      else $error("input taken while a frame is in flight");

   a_sweep_end_last: assert property (@(posedge clock) disable iff (reset)
      $fell(sweep_ff) |-> ch_ff >= sbfd_pkg::CH_W'(sbfd_pkg::NUM_CHANNELS - 2))
      else $error("sweep ended with channels left");
`endif

endmodule
`default_nettype wire
